// ----- rtl/cllp_pkg.sv -----
// Package for the linked list pool: operation codes, status codes, cursor positions
// and the field write enables of the node memory. It depends on nothing else.
package cllp_pkg;

    localparam logic [3:0] OP_CREATE  = 4'd0;
    localparam logic [3:0] OP_PREPEND = 4'd1;
    localparam logic [3:0] OP_REMOVE  = 4'd2;
    localparam logic [3:0] OP_FREE    = 4'd3;
    localparam logic [3:0] OP_FIRST   = 4'd4;
    localparam logic [3:0] OP_NEXT    = 4'd5;
    localparam logic [3:0] OP_PREV    = 4'd6;
    localparam logic [3:0] OP_CURRENT = 4'd7;
    localparam logic [3:0] OP_TRIM    = 4'd8;
    localparam logic [3:0] OP_LAST    = 4'd9;
    localparam logic [3:0] OP_COUNT   = 4'd10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EXHAUST = 2'd2;
    localparam logic [1:0] ST_NOITEM  = 2'd3;

    localparam logic [1:0] POS_ON     = 2'd0;
    localparam logic [1:0] POS_BEFORE = 2'd1;
    localparam logic [1:0] POS_AFTER  = 2'd2;

    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic pay_we;
    } cllp_wen_t;

endpackage

// ----- rtl/cursor_linked_list_pool_top.sv -----
// Top level of the linked list pool: command decoder, list table and sequencer.
// Depends on cllp_pkg and instantiates cllp_node_mem.
//
// Usage: raise start with opcode, list_id and item_value; the command is taken at
// a clock edge where start is high and busy is low. Every result appears for one
// cycle with done high and must be taken then; the receiver cannot stall.
// last_result marks the final result of a transaction.
// Sequencing: count, create and rejected commands finish in the decode state;
// lookups and remove pass through further states for the dependent reads of the
// node memory, whose read data is registered.
// Free gives one result per cycle after a first read. A new command may be
// accepted in the cycle the final result is shown.
// Reset: all lists free, the free node stack runs from node zero upwards.
// Nodes never handed out are tracked by a high water mark, so no clearing pass
// is needed and the block accepts commands straight after reset.
module cursor_linked_list_pool_top
    import cllp_pkg::*;
#(
    parameter int LIST_SLOTS = 16,
    parameter int NODE_SLOTS = 64,
    parameter int ITEM_BITS  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [3:0]           opcode,
    input  logic [3:0]           list_id,
    input  logic [ITEM_BITS-1:0] item_value,
    output logic                 done,
    output logic [1:0]           status,
    output logic [ITEM_BITS-1:0] item_out,
    output logic [3:0]           list_out,
    output logic [6:0]           count_out,
    output logic                 last_result
);

    localparam int LW  = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
    localparam int LPW = $clog2(LIST_SLOTS + 1);
    localparam int NIW = $clog2(NODE_SLOTS);
    localparam int NW  = $clog2(NODE_SLOTS + 1);
    localparam int CW  = NW;
    localparam logic [LPW-1:0] LNULL = LPW'(LIST_SLOTS);
    localparam logic [NW-1:0]  NNULL = NW'(NODE_SLOTS);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_EXEC    = 12'b0000_0000_0010,
        S_PP_POP  = 12'b0000_0000_0100,
        S_PP_WR   = 12'b0000_0000_1000,
        S_PP_WR2  = 12'b0000_0001_0000,
        S_RD_EMIT = 12'b0000_0010_0000,
        S_NX_Q    = 12'b0000_0100_0000,
        S_RM_Q    = 12'b0000_1000_0000,
        S_RM_MID  = 12'b0001_0000_0000,
        S_PUSH    = 12'b0010_0000_0000,
        S_TR_Q    = 12'b0100_0000_0000,
        S_FR_Q    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]           op_reg;
    logic [3:0]           lid_reg;
    logic [ITEM_BITS-1:0] item_reg;
    logic [NW-1:0]        node_reg, node_next;
    logic [NW-1:0]        p_reg, p_next;
    logic [NW-1:0]        x_reg, x_next;
    logic [ITEM_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [NW-1:0]        nfh_reg, nfh_next;
    logic [NW-1:0]        hwm_reg, hwm_next;
    logic [LPW-1:0]       lfh_reg, lfh_next;

    // List table, read at the addressed slot; create also reads the link at the free head.
    logic           use_reg  [LIST_SLOTS];
    logic [LPW-1:0] link_reg [LIST_SLOTS];
    logic [NW-1:0]  head_reg [LIST_SLOTS];
    logic [NW-1:0]  tail_reg [LIST_SLOTS];
    logic [NW-1:0]  cur_reg  [LIST_SLOTS];
    logic [CW-1:0]  len_reg  [LIST_SLOTS];
    logic [1:0]     pos_reg  [LIST_SLOTS];

    logic           lst_we, link_we;
    logic [LW-1:0]  lw_idx;
    logic           use_next;
    logic [NW-1:0]  head_next, tail_next, cur_next;
    logic [CW-1:0]  len_next;
    logic [1:0]     pos_next;

    logic [LW-1:0]  lidx;
    logic           lid_ok;
    logic           c_use;
    logic [NW-1:0]  c_head, c_tail, c_cur;
    logic [CW-1:0]  c_len;
    logic [1:0]     c_pos;
    logic           fwd;

    cllp_wen_t            mem_wen;
    logic [NIW-1:0]       mem_waddr, mem_raddr;
    logic [NW-1:0]        mem_wnext, mem_wprev, q_next, q_prev, step_node;
    logic [ITEM_BITS-1:0] mem_wpay, q_pay;
    logic                 mem_ren;

    logic                 emit_en, emit_last;
    logic [1:0]           emit_status;
    logic [ITEM_BITS-1:0] emit_item;
    logic [3:0]           emit_list;
    logic [CW-1:0]        emit_count;
    logic                 free_last;

    logic                 done_reg;
    logic [1:0]           status_reg;
    logic [ITEM_BITS-1:0] item_out_reg;
    logic [3:0]           list_out_reg;
    logic [6:0]           count_reg;
    logic                 last_reg;

    cllp_node_mem #(
        .NODE_SLOTS (NODE_SLOTS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_node_mem (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wnext (mem_wnext),
        .wprev (mem_wprev),
        .wpay  (mem_wpay),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .qnext (q_next),
        .qprev (q_prev),
        .qpay  (q_pay)
    );

    assign lidx   = LW'(lid_reg);
    assign lid_ok = (32'(lid_reg) < LIST_SLOTS);
    assign c_use  = use_reg[lidx];
    assign c_head = head_reg[lidx];
    assign c_tail = tail_reg[lidx];
    assign c_cur  = cur_reg[lidx];
    assign c_len  = len_reg[lidx];
    assign c_pos  = pos_reg[lidx];
    assign fwd    = (op_reg == OP_NEXT);
    assign step_node = fwd ? q_next : q_prev;
    assign free_last = ((k_reg + CW'(1)) == c_len) || (q_next == NNULL);

    always_comb
    begin
        state_next  = state_reg;
        node_next   = node_reg;
        p_next      = p_reg;
        x_next      = x_reg;
        val_next    = val_reg;
        k_next      = k_reg;
        nfh_next    = nfh_reg;
        hwm_next    = hwm_reg;
        lfh_next    = lfh_reg;
        lst_we      = 1'b0;
        link_we     = 1'b0;
        lw_idx      = lidx;
        use_next    = c_use;
        head_next   = c_head;
        tail_next   = c_tail;
        cur_next    = c_cur;
        len_next    = c_len;
        pos_next    = c_pos;
        mem_wen     = '0;
        mem_waddr   = NIW'(node_reg);
        mem_wnext   = NNULL;
        mem_wprev   = NNULL;
        mem_wpay    = item_reg;
        mem_ren     = 1'b0;
        mem_raddr   = NIW'(node_reg);
        emit_en     = 1'b0;
        emit_status = ST_OK;
        emit_item   = '0;
        emit_list   = lid_reg;
        emit_count  = c_len;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                emit_en    = 1'b1;
                if (op_reg == OP_CREATE)
                begin
                    emit_count = '0;
                    if (lfh_reg == LNULL)
                    begin
                        emit_status = ST_EXHAUST;
                    end
                    else
                    begin
                        lfh_next  = link_reg[LW'(lfh_reg)];
                        lw_idx    = LW'(lfh_reg);
                        lst_we    = 1'b1;
                        use_next  = 1'b1;
                        head_next = NNULL;
                        tail_next = NNULL;
                        cur_next  = NNULL;
                        len_next  = '0;
                        pos_next  = POS_ON;
                        emit_list = 4'(lfh_reg);
                    end
                end
                else if (op_reg > OP_COUNT || !lid_ok || !c_use)
                begin
                    emit_status = ST_INVALID;
                    emit_count  = '0;
                end
                else if (op_reg == OP_COUNT)
                begin
                    emit_status = ST_OK;
                end
                else if (op_reg == OP_PREPEND)
                begin
                    if (item_reg == '0)
                    begin
                        emit_status = ST_INVALID;
                    end
                    else if (nfh_reg == NNULL)
                    begin
                        emit_status = ST_EXHAUST;
                    end
                    else
                    begin
                        emit_en   = 1'b0;
                        node_next = nfh_reg;
                        if (nfh_reg == hwm_reg)
                        begin
                            // A node never handed out links to the one above it.
                            nfh_next   = nfh_reg + NW'(1);
                            hwm_next   = hwm_reg + NW'(1);
                            state_next = S_PP_WR;
                        end
                        else
                        begin
                            mem_ren    = 1'b1;
                            mem_raddr  = NIW'(nfh_reg);
                            state_next = S_PP_POP;
                        end
                    end
                end
                else if (op_reg == OP_FREE)
                begin
                    emit_count = '0;
                    if (c_len == '0)
                    begin
                        lst_we    = 1'b1;
                        use_next  = 1'b0;
                        head_next = NNULL;
                        tail_next = NNULL;
                        cur_next  = NNULL;
                        len_next  = '0;
                        pos_next  = POS_ON;
                        link_we   = 1'b1;
                        lfh_next  = LPW'(lid_reg);
                    end
                    else
                    begin
                        emit_en    = 1'b0;
                        mem_ren    = 1'b1;
                        mem_raddr  = NIW'(c_head);
                        node_next  = c_head;
                        k_next     = '0;
                        state_next = S_FR_Q;
                    end
                end
                else if (c_len == '0)
                begin
                    emit_status = ST_NOITEM;
                    emit_count  = '0;
                end
                else
                begin
                    emit_status = ST_NOITEM;
                    case (op_reg)
                        OP_REMOVE:
                        begin
                            if (c_pos == POS_ON && c_cur != NNULL)
                            begin
                                emit_en    = 1'b0;
                                mem_ren    = 1'b1;
                                mem_raddr  = NIW'(c_cur);
                                node_next  = c_cur;
                                state_next = S_RM_Q;
                            end
                        end
                        OP_FIRST, OP_LAST:
                        begin
                            emit_en    = 1'b0;
                            lst_we     = 1'b1;
                            pos_next   = POS_ON;
                            cur_next   = (op_reg == OP_FIRST) ? c_head : c_tail;
                            mem_ren    = 1'b1;
                            mem_raddr  = NIW'(cur_next);
                            state_next = S_RD_EMIT;
                        end
                        OP_NEXT, OP_PREV:
                        begin
                            if (c_pos == (fwd ? POS_AFTER : POS_BEFORE))
                            begin
                                emit_status = ST_NOITEM;
                            end
                            else if (c_pos != POS_ON)
                            begin
                                // Stepping in from off the list lands on the near end.
                                emit_en    = 1'b0;
                                lst_we     = 1'b1;
                                pos_next   = POS_ON;
                                cur_next   = fwd ? c_head : c_tail;
                                mem_ren    = 1'b1;
                                mem_raddr  = NIW'(cur_next);
                                state_next = S_RD_EMIT;
                            end
                            else if (c_cur != NNULL)
                            begin
                                emit_en    = 1'b0;
                                mem_ren    = 1'b1;
                                mem_raddr  = NIW'(c_cur);
                                state_next = S_NX_Q;
                            end
                        end
                        OP_CURRENT:
                        begin
                            if (c_cur != NNULL)
                            begin
                                emit_en    = 1'b0;
                                mem_ren    = 1'b1;
                                mem_raddr  = NIW'(c_cur);
                                state_next = S_RD_EMIT;
                            end
                        end
                        OP_TRIM:
                        begin
                            emit_en    = 1'b0;
                            mem_ren    = 1'b1;
                            mem_raddr  = NIW'(c_tail);
                            node_next  = c_tail;
                            state_next = S_TR_Q;
                        end
                        default:
                        begin
                            emit_status = ST_NOITEM;
                        end
                    endcase
                end
            end

            S_PP_POP:
            begin
                nfh_next   = q_next;
                state_next = S_PP_WR;
            end

            S_PP_WR:
            begin
                mem_wen   = '{next_we: 1'b1, prev_we: 1'b1, pay_we: 1'b1};
                mem_waddr = NIW'(node_reg);
                mem_wnext = (c_len == '0) ? NNULL : c_head;
                mem_wprev = NNULL;
                mem_wpay  = item_reg;
                if (c_len == '0)
                begin
                    lst_we     = 1'b1;
                    pos_next   = POS_ON;
                    head_next  = node_reg;
                    tail_next  = node_reg;
                    cur_next   = node_reg;
                    len_next   = c_len + CW'(1);
                    emit_en    = 1'b1;
                    emit_count = len_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PP_WR2;
                end
            end

            S_PP_WR2:
            begin
                mem_wen    = '{next_we: 1'b0, prev_we: 1'b1, pay_we: 1'b0};
                mem_waddr  = NIW'(c_head);
                mem_wprev  = node_reg;
                lst_we     = 1'b1;
                pos_next   = POS_ON;
                head_next  = node_reg;
                cur_next   = node_reg;
                len_next   = c_len + CW'(1);
                emit_en    = 1'b1;
                emit_count = len_next;
                state_next = S_IDLE;
            end

            S_RD_EMIT:
            begin
                emit_en    = 1'b1;
                emit_item  = q_pay;
                state_next = S_IDLE;
            end

            S_NX_Q:
            begin
                lst_we = 1'b1;
                if (step_node == NNULL)
                begin
                    pos_next    = fwd ? POS_AFTER : POS_BEFORE;
                    cur_next    = NNULL;
                    emit_en     = 1'b1;
                    emit_status = ST_NOITEM;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next   = step_node;
                    mem_ren    = 1'b1;
                    mem_raddr  = NIW'(step_node);
                    state_next = S_RD_EMIT;
                end
            end

            S_RM_Q:
            begin
                val_next   = q_pay;
                x_next     = q_next;
                p_next     = q_prev;
                lst_we     = 1'b1;
                len_next   = c_len - CW'(1);
                state_next = S_PUSH;
                if (c_len == CW'(1))
                begin
                    head_next = NNULL;
                    tail_next = NNULL;
                    cur_next  = NNULL;
                    len_next  = '0;
                    pos_next  = POS_ON;
                end
                else if (node_reg == c_tail)
                begin
                    tail_next = q_prev;
                    cur_next  = q_prev;
                    mem_wen   = '{next_we: 1'b1, prev_we: 1'b0, pay_we: 1'b0};
                    mem_waddr = NIW'(q_prev);
                    mem_wnext = NNULL;
                end
                else if (node_reg == c_head)
                begin
                    head_next = q_next;
                    cur_next  = q_next;
                    mem_wen   = '{next_we: 1'b0, prev_we: 1'b1, pay_we: 1'b0};
                    mem_waddr = NIW'(q_next);
                    mem_wprev = NNULL;
                end
                else
                begin
                    // An inner node needs both neighbours relinked, one per cycle.
                    cur_next   = q_next;
                    mem_wen    = '{next_we: 1'b0, prev_we: 1'b1, pay_we: 1'b0};
                    mem_waddr  = NIW'(q_next);
                    mem_wprev  = q_prev;
                    state_next = S_RM_MID;
                end
            end

            S_RM_MID:
            begin
                mem_wen    = '{next_we: 1'b1, prev_we: 1'b0, pay_we: 1'b0};
                mem_waddr  = NIW'(p_reg);
                mem_wnext  = x_reg;
                state_next = S_PUSH;
            end

            S_TR_Q:
            begin
                val_next   = q_pay;
                lst_we     = 1'b1;
                state_next = S_PUSH;
                if (c_len == CW'(1))
                begin
                    head_next = NNULL;
                    tail_next = NNULL;
                    cur_next  = NNULL;
                    len_next  = '0;
                    pos_next  = POS_ON;
                end
                else
                begin
                    tail_next = q_prev;
                    cur_next  = q_prev;
                    len_next  = c_len - CW'(1);
                    mem_wen   = '{next_we: 1'b1, prev_we: 1'b0, pay_we: 1'b0};
                    mem_waddr = NIW'(q_prev);
                    mem_wnext = NNULL;
                end
            end

            S_PUSH:
            begin
                mem_wen    = '{next_we: 1'b1, prev_we: 1'b0, pay_we: 1'b0};
                mem_waddr  = NIW'(node_reg);
                mem_wnext  = nfh_reg;
                nfh_next   = node_reg;
                emit_en    = 1'b1;
                emit_item  = val_reg;
                state_next = S_IDLE;
            end

            S_FR_Q:
            begin
                // Each node goes back on the free stack as its item is sent out.
                mem_wen    = '{next_we: 1'b1, prev_we: 1'b0, pay_we: 1'b0};
                mem_waddr  = NIW'(node_reg);
                mem_wnext  = nfh_reg;
                nfh_next   = node_reg;
                emit_en    = 1'b1;
                emit_item  = q_pay;
                emit_count = '0;
                emit_last  = free_last;
                if (free_last)
                begin
                    lst_we     = 1'b1;
                    use_next   = 1'b0;
                    head_next  = NNULL;
                    tail_next  = NNULL;
                    cur_next   = NNULL;
                    len_next   = '0;
                    pos_next   = POS_ON;
                    link_we    = 1'b1;
                    lfh_next   = LPW'(lid_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = NIW'(q_next);
                    node_next = q_next;
                    k_next    = k_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nfh_reg   <= '0;
            hwm_reg   <= '0;
            lfh_reg   <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < LIST_SLOTS; i++)
            begin
                use_reg[i]  <= 1'b0;
                link_reg[i] <= LPW'(i + 1);
                head_reg[i] <= NNULL;
                tail_reg[i] <= NNULL;
                cur_reg[i]  <= NNULL;
                len_reg[i]  <= '0;
                pos_reg[i]  <= POS_ON;
            end
        end
        else
        begin
            state_reg <= state_next;
            nfh_reg   <= nfh_next;
            hwm_reg   <= hwm_next;
            lfh_reg   <= lfh_next;
            done_reg  <= emit_en;
            if (lst_we)
            begin
                use_reg[lw_idx]  <= use_next;
                head_reg[lw_idx] <= head_next;
                tail_reg[lw_idx] <= tail_next;
                cur_reg[lw_idx]  <= cur_next;
                len_reg[lw_idx]  <= len_next;
                pos_reg[lw_idx]  <= pos_next;
            end
            if (link_we)
            begin
                link_reg[lidx] <= lfh_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= opcode;
            lid_reg  <= list_id;
            item_reg <= item_value;
        end
        node_reg <= node_next;
        p_reg    <= p_next;
        x_reg    <= x_next;
        val_reg  <= val_next;
        k_reg    <= k_next;
        if (emit_en)
        begin
            status_reg   <= emit_status;
            item_out_reg <= emit_item;
            list_out_reg <= emit_list;
            count_reg    <= 7'(emit_count);
            last_reg     <= emit_last;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign item_out    = item_out_reg;
    assign list_out    = list_out_reg;
    assign count_out   = count_reg;
    assign last_result = last_reg;

endmodule

// ----- rtl/cllp_node_mem.sv -----
// Node memory of the pool: next link, previous link and payload of every node.
// One write address with per-field enables, one read address with registered data.
// Depends on cllp_pkg for the write enable type.
module cllp_node_mem
    import cllp_pkg::*;
#(
    parameter int NODE_SLOTS = 64,
    parameter int ITEM_BITS  = 32
)
(
    input  logic                          clk,
    input  cllp_wen_t                     wen,
    input  logic [$clog2(NODE_SLOTS)-1:0] waddr,
    input  logic [$clog2(NODE_SLOTS+1)-1:0] wnext,
    input  logic [$clog2(NODE_SLOTS+1)-1:0] wprev,
    input  logic [ITEM_BITS-1:0]          wpay,
    input  logic                          ren,
    input  logic [$clog2(NODE_SLOTS)-1:0] raddr,
    output logic [$clog2(NODE_SLOTS+1)-1:0] qnext,
    output logic [$clog2(NODE_SLOTS+1)-1:0] qprev,
    output logic [ITEM_BITS-1:0]          qpay
);

    localparam int NW = $clog2(NODE_SLOTS + 1);

    logic [NW-1:0]        next_mem [NODE_SLOTS];
    logic [NW-1:0]        prev_mem [NODE_SLOTS];
    logic [ITEM_BITS-1:0] pay_mem  [NODE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wen.next_we)
        begin
            next_mem[waddr] <= wnext;
        end
        if (wen.prev_we)
        begin
            prev_mem[waddr] <= wprev;
        end
        if (wen.pay_we)
        begin
            pay_mem[waddr] <= wpay;
        end
        if (ren)
        begin
            qnext <= next_mem[raddr];
            qprev <= prev_mem[raddr];
            qpay  <= pay_mem[raddr];
        end
    end

endmodule
